FILE: design/vprf_pkg.sv
// shared types, register indexes and cell mask helper for the volume paeth residual filter
`timescale 1ns / 1ps

package vprf_pkg;

  localparam int CELL_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_CELLS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER_ROWS = 2'd3;

  // predictor codes
  localparam logic MODE_XOR   = 1'b0;
  localparam logic MODE_PAETH = 1'b1;

  // neighbour availability and position flags for one cell
  typedef struct packed {
    logic col_zero;
    logic has_above;
    logic has_back;
    logic row_end;
    logic layer_end;
  } pos_info_t;

  // low-byte mask for a cell width given in bytes
  function automatic logic [CELL_W-1:0] cell_mask(input logic [3:0] cb);
    logic [CELL_W-1:0] m;
    case (cb)
      4'd0, 4'd1: m = 64'h0000_0000_0000_00FF;
      4'd2:       m = 64'h0000_0000_0000_FFFF;
      4'd3:       m = 64'h0000_0000_00FF_FFFF;
      4'd4:       m = 64'h0000_0000_FFFF_FFFF;
      4'd5:       m = 64'h0000_00FF_FFFF_FFFF;
      4'd6:       m = 64'h0000_FFFF_FFFF_FFFF;
      4'd7:       m = 64'h00FF_FFFF_FFFF_FFFF;
      default:    m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

FILE: design/volume_paeth_residual_filter.sv
// top level of the volume paeth residual filter
//
//   channel  | signals                              | carries
//   ---------+--------------------------------------+-------------------------------
//   cell     | cell_valid, cell_ready, cell_value   | one original cell per request
//   res      | res_valid, res_ready, residual,      | one residual per cell, with
//            | row_end, layer_end                   | row and layer end marks
//   cfg      | cfg_valid, cfg_ready, cfg_index,     | register writes, always ready
//            | cfg_data                             |
//
// one cell per cycle while res_ready is high; cells pass the compute and result registers.
// line buffer reads are registered at the request, the predictor runs in the next cycle.
// rst is synchronous: position, flags and valid bits clear, line buffers stay as they are.
// a stalled result holds the residual register and then the compute stage; cell_ready
// drops only when both are full and res_ready is low.
`timescale 1ns / 1ps

module volume_paeth_residual_filter import vprf_pkg::*; #(
  parameter int MAX_ROW_CELLS = 256,
  parameter int MAX_LAYER_ROWS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cell_valid,
  output logic                  cell_ready,
  input  logic [CELL_W-1:0]     cell_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [CELL_W-1:0]     residual,
  output logic                  row_end,
  output logic                  layer_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (MAX_ROW_CELLS > 1) ? $clog2(MAX_ROW_CELLS) : 1;
  localparam int LW = (MAX_LAYER_ROWS > 1) ? $clog2(MAX_LAYER_ROWS) : 1;

  logic              mode;
  logic [3:0]        cell_bytes;
  logic [8:0]        row_cells;
  logic [4:0]        layer_rows;
  logic [CELL_W-1:0] mask;

  logic              cell_fire;
  logic [CELL_W-1:0] cur_in;
  logic [CELL_W-1:0] left_cell;
  logic [CW-1:0]     col;
  logic [LW-1:0]     row;
  pos_info_t         info;
  logic [CELL_W-1:0] above_q;
  logic [CELL_W-1:0] back_q;

  logic              s1_valid;
  logic [CELL_W-1:0] s1_cur;
  logic [CELL_W-1:0] s1_left;
  pos_info_t         s1_info;
  logic [CELL_W-1:0] above_left_cell;
  logic              res_free;
  logic              s1_adv;
  logic [CELL_W-1:0] residual_next;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_XOR;
      cell_bytes <= 4'd1;
      row_cells  <= 9'd256;
      layer_rows <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MODE:       mode       <= cfg_data[0];
        REG_CELL_BYTES: cell_bytes <= cfg_data[3:0];
        REG_ROW_CELLS:  row_cells  <= cfg_data[8:0];
        REG_LAYER_ROWS: layer_rows <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign mask = cell_mask(cell_bytes);

  // pipeline flow control
  assign res_free   = !res_valid || res_ready;
  assign s1_adv     = s1_valid && res_free;
  assign cell_ready = !s1_valid || res_free;
  assign cell_fire  = cell_valid && cell_ready;
  assign cur_in     = cell_value & mask;

  vprf_pos #(
    .MAX_ROW_CELLS (MAX_ROW_CELLS),
    .MAX_LAYER_ROWS(MAX_LAYER_ROWS)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .step      (cell_fire),
    .row_cells (row_cells),
    .layer_rows(layer_rows),
    .col       (col),
    .row       (row),
    .info      (info)
  );

  vprf_store #(
    .MAX_ROW_CELLS (MAX_ROW_CELLS),
    .MAX_LAYER_ROWS(MAX_LAYER_ROWS)
  ) u_store (
    .clk    (clk),
    .step   (cell_fire),
    .col    (col),
    .row    (row),
    .wr_data(cur_in),
    .above_q(above_q),
    .back_q (back_q)
  );

  // left neighbour is the previous accepted cell
  always_ff @(posedge clk) begin
    if (rst) begin
      left_cell <= '0;
    end else if (cell_fire) begin
      left_cell <= cur_in;
    end
  end

  // compute stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cell_ready) begin
      s1_valid <= cell_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_fire) begin
      s1_cur  <= cur_in;
      s1_left <= left_cell;
      s1_info <= info;
    end
  end

  // above of one cell is above-left of the next
  always_ff @(posedge clk) begin
    if (rst) begin
      above_left_cell <= '0;
    end else if (s1_adv) begin
      above_left_cell <= above_q;
    end
  end

  vprf_pred u_pred (
    .mode     (mode),
    .mask     (mask),
    .info     (s1_info),
    .cur      (s1_cur),
    .left_raw (s1_left),
    .above_raw(above_q),
    .aleft_raw(above_left_cell),
    .back_raw (back_q),
    .residual (residual_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      residual  <= residual_next;
      row_end   <= s1_info.row_end;
      layer_end <= s1_info.layer_end;
    end
  end

`ifndef SYNTHESIS
  // a blocked compute stage keeps its cell
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !res_free |=> s1_valid && $stable(s1_cur))
    else $error("compute stage lost its cell while stalled");

  // a cell leaving the compute stage lands in the result register
  a_s1_to_res: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> res_valid)
    else $error("result register missed a cell");

  // layer end only on a row end
  a_layer_row: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !layer_end || row_end)
    else $error("layer end without row end");

  // column wraps after the last cell of a row
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    cell_fire && info.row_end |=> col == '0)
    else $error("column did not wrap at row end");
`endif

endmodule

FILE: design/vprf_pos.sv
// column, row and layer position tracking for the volume paeth residual filter
`timescale 1ns / 1ps

module vprf_pos import vprf_pkg::*; #(
  parameter int MAX_ROW_CELLS = 256,
  parameter int MAX_LAYER_ROWS = 16,
  localparam int CW = (MAX_ROW_CELLS > 1) ? $clog2(MAX_ROW_CELLS) : 1,
  localparam int LW = (MAX_LAYER_ROWS > 1) ? $clog2(MAX_LAYER_ROWS) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [8:0]    row_cells,
  input  logic [4:0]    layer_rows,
  output logic [CW-1:0] col,
  output logic [LW-1:0] row,
  output pos_info_t     info
);

  localparam int RCW = (CW + 1 > 9) ? CW + 1 : 9;
  localparam int LCW = (LW + 1 > 5) ? LW + 1 : 5;

  logic           layer_seen;
  logic [RCW-1:0] rc_eff;
  logic [LCW-1:0] lr_eff;

  // clamp row length and layer height into range
  always_comb begin
    if (row_cells == '0) begin
      rc_eff = RCW'(1);
    end else if (RCW'(row_cells) > RCW'(MAX_ROW_CELLS)) begin
      rc_eff = RCW'(MAX_ROW_CELLS);
    end else begin
      rc_eff = RCW'(row_cells);
    end
    if (layer_rows == '0) begin
      lr_eff = LCW'(1);
    end else if (LCW'(layer_rows) > LCW'(MAX_LAYER_ROWS)) begin
      lr_eff = LCW'(MAX_LAYER_ROWS);
    end else begin
      lr_eff = LCW'(layer_rows);
    end
  end

  // flags for the cell at the current position
  always_comb begin
    info.col_zero  = (col == '0);
    info.has_above = (row != '0);
    info.has_back  = layer_seen;
    info.row_end   = (RCW'(col) + RCW'(1)) >= rc_eff;
    info.layer_end = info.row_end && ((LCW'(row) + LCW'(1)) >= lr_eff);
  end

  // advance position on each request
  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      layer_seen <= 1'b0;
    end else if (step) begin
      if (info.row_end) begin
        col <= '0;
        if (info.layer_end) begin
          row        <= '0;
          layer_seen <= 1'b1;
        end else begin
          row <= row + LW'(1);
        end
      end else begin
        col <= col + CW'(1);
      end
    end
  end

endmodule

FILE: design/vprf_store.sv
// row and layer line buffers, written and read once per request
`timescale 1ns / 1ps

module vprf_store import vprf_pkg::*; #(
  parameter int MAX_ROW_CELLS = 256,
  parameter int MAX_LAYER_ROWS = 16,
  localparam int CW = (MAX_ROW_CELLS > 1) ? $clog2(MAX_ROW_CELLS) : 1,
  localparam int LW = (MAX_LAYER_ROWS > 1) ? $clog2(MAX_LAYER_ROWS) : 1
) (
  input  logic              clk,
  input  logic              step,
  input  logic [CW-1:0]     col,
  input  logic [LW-1:0]     row,
  input  logic [CELL_W-1:0] wr_data,
  output logic [CELL_W-1:0] above_q,
  output logic [CELL_W-1:0] back_q
);

  localparam int ABOVE_DEPTH = 2 ** CW;
  localparam int BACK_DEPTH = 2 ** (CW + LW);

  logic [CELL_W-1:0] above_mem [ABOVE_DEPTH];
  logic [CELL_W-1:0] back_mem  [BACK_DEPTH];

  // previous row: read old value, then replace with the current cell
  always_ff @(posedge clk) begin
    if (step) begin
      above_q        <= above_mem[col];
      above_mem[col] <= wr_data;
    end
  end

  // previous layer: same row and column one layer back
  always_ff @(posedge clk) begin
    if (step) begin
      back_q              <= back_mem[{row, col}];
      back_mem[{row, col}] <= wr_data;
    end
  end

endmodule

FILE: design/vprf_pred.sv
// xor and four-neighbour paeth residual for one cell
`timescale 1ns / 1ps

module vprf_pred import vprf_pkg::*; (
  input  logic              mode,
  input  logic [CELL_W-1:0] mask,
  input  pos_info_t         info,
  input  logic [CELL_W-1:0] cur,
  input  logic [CELL_W-1:0] left_raw,
  input  logic [CELL_W-1:0] above_raw,
  input  logic [CELL_W-1:0] aleft_raw,
  input  logic [CELL_W-1:0] back_raw,
  output logic [CELL_W-1:0] residual
);

  // wide enough for a + b + d - 2c with no overflow
  localparam int DW = CELL_W + 3;

  logic [CELL_W-1:0] a, b, c, d, pred;
  logic signed [DW-1:0] sa, sb, sc, sd;
  logic signed [DW-1:0] da, db, dc, dd;
  logic [DW-1:0] pa, pb, pc, pd;

  // missing neighbours count as zero
  always_comb begin
    a = left_raw & mask;
    b = info.has_above ? (above_raw & mask) : '0;
    c = info.has_above ? (aleft_raw & mask) : '0;
    d = info.has_back ? (back_raw & mask) : '0;
  end

  // signed distances from the four-term estimate
  always_comb begin
    sa = signed'({3'b000, a});
    sb = signed'({3'b000, b});
    sc = signed'({3'b000, c});
    sd = signed'({3'b000, d});
    da = sb + sd - sc;
    db = sa + sd - sc;
    dc = sa + sb + sd - sc - sc;
    dd = sa + sb - sc;
    pa = da[DW-1] ? DW'(-da) : DW'(da);
    pb = db[DW-1] ? DW'(-db) : DW'(db);
    pc = dc[DW-1] ? DW'(-dc) : DW'(dc);
    pd = dd[DW-1] ? DW'(-dd) : DW'(dd);
  end

  // nearest neighbour wins, ties go to the earlier one
  always_comb begin
    if (pa <= pb && pa <= pc && pa <= pd) begin
      pred = a;
    end else if (pb <= pc && pb <= pd) begin
      pred = b;
    end else if (pc <= pd) begin
      pred = c;
    end else begin
      pred = d;
    end
  end

  // residual per mode, first cell of a row handled apart
  always_comb begin
    if (mode == MODE_PAETH) begin
      if (info.col_zero) begin
        residual = (cur - b - d) & mask;
      end else begin
        residual = (cur - pred) & mask;
      end
    end else begin
      residual = info.col_zero ? cur : ((cur ^ a) & mask);
    end
  end

endmodule
